@@ sv/bitmap_slot_allocator_unit_macros.svh @@
`ifndef BITMAP_SLOT_ALLOCATOR_UNIT_MACROS_SVH
`define BITMAP_SLOT_ALLOCATOR_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low
`define BSA_ASSERT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low
`define BSA_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ sv/bsa_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package bsa_pkg;

	// Field widths
	localparam int SIZE_W    = 13;
	localparam int OFF_W     = 22;
	localparam int STATUS_W  = 2;
	localparam int IDX_W     = 10;
	localparam int FREE_W    = 11;
	localparam int S_TDATA_W = 24;
	localparam int M_TDATA_W = 48;

	// Object size in units of eight bytes (1..1024)
	localparam int UNITS_W = 11;
	localparam int ESIZE_W = UNITS_W + 3;

	// Shared divider: covers byte_offset / 8 and any slot number
	localparam int DIV_W     = OFF_W - 3;
	localparam int DIV_CNT_W = $clog2(DIV_W + 1);

	// Request kind
	localparam logic MODE_ALLOC = 1'b0;
	localparam logic MODE_FREE  = 1'b1;

	// Result status
	localparam logic [STATUS_W-1:0] STAT_OK     = 2'd0;
	localparam logic [STATUS_W-1:0] STAT_FULL   = 2'd1;
	localparam logic [STATUS_W-1:0] STAT_BADOFF = 2'd2;
	localparam logic [STATUS_W-1:0] STAT_DFREE  = 2'd3;

	typedef struct packed {
		logic             start;
		logic [DIV_W-1:0] dividend;
		logic [DIV_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [DIV_W-1:0] quot;
		logic [DIV_W-1:0] rem;
	} div_rsp_t;

endpackage

`default_nettype wire

@@ sv/bsa_map_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none

module bsa_map_ram #(
	parameter int DEPTH = 32,
	parameter int WIDTH = 32,
	parameter int AW    = 5
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// One write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

@@ sv/bsa_divider.sv @@
`timescale 1ns / 1ps
`default_nettype none

module bsa_divider (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire bsa_pkg::div_req_t req,
	output bsa_pkg::div_rsp_t      rsp
);

	import bsa_pkg::*;

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [DIV_W-1:0]     rem_q;
	logic [DIV_W-1:0]     quo_q;
	logic [DIV_W-1:0]     dvs_q;

	logic [DIV_W:0]       shifted;
	logic [DIV_W:0]       diff;
	logic                 ge;

	// Restoring step: one quotient bit per cycle
	assign shifted = {rem_q, quo_q[DIV_W-1]};
	assign diff    = shifted - {1'b0, dvs_q};
	assign ge      = shifted >= {1'b0, dvs_q};

	// Control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == DIV_CNT_W'(DIV_W - 1));
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DIV_CNT_W'(DIV_W - 1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	// Datapath: dividend shifts out of quo_q while quotient bits shift in
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= req.dividend;
			dvs_q <= req.divisor;
		end else if (busy_q) begin
			rem_q <= ge ? diff[DIV_W-1:0] : shifted[DIV_W-1:0];
			quo_q <= {quo_q[DIV_W-2:0], ge};
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = quo_q;
	assign rsp.rem  = rem_q;

endmodule

`default_nettype wire

@@ sv/bitmap_slot_allocator_unit.sv @@
// Fixed-size slot allocator over a bitmap of used slots held in one synchronous RAM of
// ceil(NUM_SLOTS/WORD_BITS) words; WORD_BITS must be a power of two. After reset the block
// clears the bitmap one word per cycle with s_tready low; cfg writes are taken meanwhile.
// One request is handled at a time. An allocate reads one bitmap word per cycle from word 0
// until it finds one with a free slot, then sets the bit; a full pool is reported without
// a scan. A free divides the offset by the object size with a one-bit-per-cycle divider
// (19 steps), splits the slot into word and bit, then reads, checks and writes back the
// word; an offset past the pool skips the read, and one that is not a multiple of eight
// also skips the division. The next request can be taken while the previous result still
// waits on the master side; a result held there stalls the request after it until the
// result is taken.
`timescale 1ns / 1ps
`default_nettype none
`include "bitmap_slot_allocator_unit_macros.svh"

module bitmap_slot_allocator_unit #(
	parameter int NUM_SLOTS = 1024,
	parameter int WORD_BITS = 32
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	// cfg_wdata: object_size
	input  wire logic                          cfg_we,
	input  wire logic [bsa_pkg::SIZE_W-1:0]    cfg_wdata,
	input  wire logic                          s_tvalid,
	output logic                               s_tready,
	// s_tdata: byte_offset[21:0], zero pad [23:22]
	input  wire logic [bsa_pkg::S_TDATA_W-1:0] s_tdata,
	// s_tuser: mode[0]
	input  wire logic [0:0]                    s_tuser,
	output logic                               m_tvalid,
	input  wire logic                          m_tready,
	// m_tdata: slot_index[9:0], slot_offset[31:10], free_slots[42:32], zero pad [47:43]
	output logic [bsa_pkg::M_TDATA_W-1:0]      m_tdata,
	// m_tuser: status[1:0]
	output logic [bsa_pkg::STATUS_W-1:0]       m_tuser
);

	import bsa_pkg::*;

	localparam int NUM_WORDS = (NUM_SLOTS + WORD_BITS - 1) / WORD_BITS;
	localparam int AW        = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
	localparam int BW        = $clog2(WORD_BITS);
	localparam int SW        = $clog2(NUM_SLOTS);
	localparam int CW        = $clog2(NUM_SLOTS + 1);
	localparam int LAST_BITS = NUM_SLOTS - (NUM_WORDS - 1) * WORD_BITS;
	localparam logic [WORD_BITS-1:0] LAST_VALID = {WORD_BITS{1'b1}} >> (WORD_BITS - LAST_BITS);
	localparam logic [AW-1:0] LAST_WORD = AW'(NUM_WORDS - 1);

	// Sequencer states
	localparam logic [3:0] S_CLEAR    = 4'd0;
	localparam logic [3:0] S_IDLE     = 4'd1;
	localparam logic [3:0] S_SCAN     = 4'd2;
	localparam logic [3:0] S_SETBIT   = 4'd3;
	localparam logic [3:0] S_DIV_SLOT = 4'd4;
	localparam logic [3:0] S_FREAD    = 4'd6;
	localparam logic [3:0] S_FCHECK   = 4'd7;
	localparam logic [3:0] S_OUT      = 4'd8;

	logic [3:0]           state_q;
	logic [SIZE_W-1:0]    cfg_size_q;
	logic [CW-1:0]        free_count_q;
	logic [AW-1:0]        clr_q;
	logic [AW-1:0]        rd_ptr_q;
	logic [SW-1:0]        rd_base_q;
	logic                 pend_s1;
	logic [AW-1:0]        chk_w_s1;
	logic [SW-1:0]        base_s1;
	logic                 m_tvalid_q;

	logic [AW-1:0]        waddr_q;
	logic [WORD_BITS-1:0] word_q;
	logic [SW-1:0]        slot_q;
	logic [BW-1:0]        bit_q;
	logic [OFF_W-1:0]     off_q;
	logic [STATUS_W-1:0]  res_status_q;
	logic [SW-1:0]        res_slot_q;
	logic [OFF_W-1:0]     res_off_q;
	logic [STATUS_W-1:0]  out_status_q;
	logic [M_TDATA_W-1:0] out_data_q;

	logic                 div_start_q;
	logic [DIV_W-1:0]     div_dividend_q;
	logic [DIV_W-1:0]     div_divisor_q;
	div_req_t             div_req;
	div_rsp_t             div_rsp;

	logic                 ram_we;
	logic [AW-1:0]        ram_waddr;
	logic [WORD_BITS-1:0] ram_wdata;
	logic [AW-1:0]        ram_raddr;
	logic [WORD_BITS-1:0] ram_rdata;

	logic                 in_fire;
	logic                 out_free;
	logic [ESIZE_W-1:0]   size_sum;
	logic [UNITS_W-1:0]   units_raw;
	logic [UNITS_W-1:0]   units;
	logic [ESIZE_W-1:0]   size_eff;
	logic [WORD_BITS-1:0] avail;
	logic [WORD_BITS-1:0] lowbit;
	logic [BW-1:0]        low_idx;
	logic                 found;
	logic [SW:0]          found_slot;
	logic [SW+ESIZE_W-1:0] prod;
	logic                 slot_used;
	logic                 offset_bad;

	// Effective object size: round up to eight, zero acts as eight
	assign size_sum  = ESIZE_W'(cfg_size_q) + ESIZE_W'(7);
	assign units_raw = size_sum[ESIZE_W-1:3];
	assign units     = (units_raw == '0) ? UNITS_W'(1) : units_raw;
	assign size_eff  = {units, 3'b000};

	assign in_fire  = s_tvalid && s_tready;
	assign s_tready = (state_q == S_IDLE);
	assign out_free = !m_tvalid_q || m_tready;

	// Scan check: lowest free slot in the word returned by the RAM
	always_comb begin
		avail  = ~ram_rdata & ((chk_w_s1 == LAST_WORD) ? LAST_VALID : {WORD_BITS{1'b1}});
		lowbit = avail & (~avail + 1'b1);
		low_idx = '0;
		for (int i = 0; i < WORD_BITS; i++) begin
			if (lowbit[i]) begin
				low_idx = low_idx | BW'(i);
			end
		end
	end
	assign found      = (state_q == S_SCAN) && pend_s1 && (avail != '0);
	assign found_slot = (SW + 1)'(base_s1) + (SW + 1)'(low_idx);
	assign prod       = slot_q * size_eff;

	// Free checks
	assign offset_bad = (div_rsp.rem != '0) || (div_rsp.quot >= DIV_W'(NUM_SLOTS));
	assign slot_used  = ram_rdata[bit_q];

	// Bitmap RAM ports
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = waddr_q;
		ram_wdata = ram_rdata & ~(WORD_BITS'(1) << bit_q);
		case (state_q)
			S_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_q;
				ram_wdata = '0;
			end
			S_SETBIT: begin
				ram_we    = 1'b1;
				ram_wdata = word_q;
			end
			S_FCHECK: begin
				ram_we = slot_used;
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end
	assign ram_raddr = (state_q == S_SCAN) ? rd_ptr_q : waddr_q;

	bsa_map_ram #(
		.DEPTH(NUM_WORDS),
		.WIDTH(WORD_BITS),
		.AW   (AW)
	) u_map (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign div_req.start    = div_start_q;
	assign div_req.dividend = div_dividend_q;
	assign div_req.divisor  = div_divisor_q;

	bsa_divider u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (div_req),
		.rsp   (div_rsp)
	);

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_CLEAR;
			cfg_size_q   <= SIZE_W'(8);
			free_count_q <= CW'(NUM_SLOTS);
			clr_q        <= '0;
			rd_ptr_q     <= '0;
			rd_base_q    <= '0;
			pend_s1      <= 1'b0;
			div_start_q  <= 1'b0;
			m_tvalid_q   <= 1'b0;
		end else begin
			if (cfg_we) begin
				cfg_size_q <= cfg_wdata;
			end
			// aligned free: start the offset division
			div_start_q <= in_fire && (s_tuser[0] == MODE_FREE) && (s_tdata[2:0] == 3'b000);
			pend_s1     <= (state_q == S_SCAN) && !found;
			if ((state_q == S_OUT) && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == LAST_WORD) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					rd_ptr_q  <= '0;
					rd_base_q <= '0;
					if (in_fire) begin
						if (s_tuser[0] == MODE_ALLOC) begin
							state_q <= (free_count_q == '0) ? S_OUT : S_SCAN;
						end else if (s_tdata[2:0] != 3'b000) begin
							state_q <= S_OUT;
						end else begin
							state_q <= S_DIV_SLOT;
						end
					end
				end
				S_SCAN: begin
					if (rd_ptr_q != LAST_WORD) begin
						rd_ptr_q  <= rd_ptr_q + 1'b1;
						rd_base_q <= SW'(rd_base_q + WORD_BITS);
					end
					if (found) begin
						state_q <= S_SETBIT;
					end
				end
				S_SETBIT: begin
					free_count_q <= free_count_q - 1'b1;
					state_q      <= S_OUT;
				end
				S_DIV_SLOT: begin
					if (div_rsp.done) begin
						state_q <= offset_bad ? S_OUT : S_FREAD;
					end
				end
				S_FREAD: begin
					state_q <= S_FCHECK;
				end
				S_FCHECK: begin
					if (slot_used && (free_count_q < CW'(NUM_SLOTS))) begin
						free_count_q <= free_count_q + 1'b1;
					end
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (state_q == S_SCAN) begin
			chk_w_s1 <= rd_ptr_q;
			base_s1  <= rd_base_q;
		end
		case (state_q)
			S_IDLE: begin
				off_q          <= s_tdata[OFF_W-1:0];
				div_dividend_q <= s_tdata[OFF_W-1:3];
				div_divisor_q  <= DIV_W'(units);
				res_slot_q     <= '0;
				res_off_q      <= '0;
				if (s_tuser[0] == MODE_ALLOC) begin
					res_status_q <= STAT_FULL;
				end else begin
					res_status_q <= STAT_BADOFF;
				end
			end
			S_SCAN: begin
				word_q  <= ram_rdata | lowbit;
				waddr_q <= chk_w_s1;
				slot_q  <= found_slot[SW-1:0];
			end
			S_SETBIT: begin
				res_status_q <= STAT_OK;
				res_slot_q   <= slot_q;
				res_off_q    <= OFF_W'(prod);
			end
			S_DIV_SLOT: begin
				// slot splits into word address and bit position
				slot_q  <= SW'(div_rsp.quot);
				waddr_q <= AW'(div_rsp.quot[DIV_W-1:BW]);
				bit_q   <= div_rsp.quot[BW-1:0];
			end
			S_FCHECK: begin
				if (slot_used) begin
					res_status_q <= STAT_OK;
					res_slot_q   <= slot_q;
					res_off_q    <= off_q;
				end else begin
					res_status_q <= STAT_DFREE;
				end
			end
			S_OUT: begin
				if (out_free) begin
					out_status_q <= res_status_q;
					out_data_q   <= {5'b0, FREE_W'(free_count_q), res_off_q,
						IDX_W'(res_slot_q)};
				end
			end
			default: begin
				out_status_q <= out_status_q;
			end
		endcase
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_status_q;

	// Checks
	`BSA_ASSERT(a_count_bound, 1'b1, free_count_q <= CW'(NUM_SLOTS), "free count above pool size")
	`BSA_ASSERT(a_scan_has_room, state_q == S_SCAN, free_count_q != '0, "scan with empty pool")
	`BSA_ASSERT(a_map_write_state, ram_we,
		state_q == S_CLEAR || state_q == S_SETBIT || state_q == S_FCHECK,
		"bitmap written outside a write state")
	`BSA_ASSERT_NEXT(a_full_reply, in_fire && s_tuser[0] == MODE_ALLOC && free_count_q == '0,
		state_q == S_OUT && res_status_q == STAT_FULL, "full pool not reported at once")

endmodule

`default_nettype wire

@@ verif/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
	import bsa_pkg::*;

	localparam int SLOTS        = 1024;
	localparam int OFF_MAX      = (1 << OFF_W) - 1;
	localparam int LIMIT_CYCLES = 1_000_000;
	localparam int HOLD_CYCLES  = 400;
	localparam int DRAIN_CYCLES = 100;
	localparam int REPORT_MAX   = 10;
	localparam int DIR_N        = 25;
	localparam int PHASE_N      = 5;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [IDX_W-1:0]    slot_index;
		logic [OFF_W-1:0]    slot_offset;
		logic [FREE_W-1:0]   free_slots;
	} slot_result_t;

	typedef struct packed {
		logic         mode;
		slot_result_t res;
	} slot_due_t;

	typedef enum bit {ROW_REQ, ROW_SIZE} row_kind_e;

	// Directed row: a request with its result, or an object_size write (value in arg)
	typedef struct packed {
		row_kind_e           kind;
		logic                mode;
		logic [OFF_W-1:0]    arg;
		logic [STATUS_W-1:0] status;
		logic [IDX_W-1:0]    slot_index;
		logic [OFF_W-1:0]    slot_offset;
		logic [FREE_W-1:0]   free_slots;
	} dir_row_t;

	localparam dir_row_t DIR_ROWS [DIR_N] = '{
		'{ROW_SIZE, MODE_ALLOC, 22'd8,       STAT_OK,     10'd0, 22'd0,    11'd0},
		'{ROW_REQ,  MODE_ALLOC, 22'd0,       STAT_OK,     10'd0, 22'd0,    11'd1023},
		'{ROW_REQ,  MODE_ALLOC, 22'h3FFFFF,  STAT_OK,     10'd1, 22'd8,    11'd1022},
		'{ROW_REQ,  MODE_FREE,  22'd8,       STAT_OK,     10'd1, 22'd8,    11'd1023},
		'{ROW_REQ,  MODE_FREE,  22'd8,       STAT_DFREE,  10'd0, 22'd0,    11'd1023},
		'{ROW_REQ,  MODE_FREE,  22'd3,       STAT_BADOFF, 10'd0, 22'd0,    11'd1023},
		'{ROW_REQ,  MODE_FREE,  22'd8192,    STAT_BADOFF, 10'd0, 22'd0,    11'd1023},
		'{ROW_REQ,  MODE_FREE,  22'h3FFFFF,  STAT_BADOFF, 10'd0, 22'd0,    11'd1023},
		'{ROW_REQ,  MODE_FREE,  22'd0,       STAT_OK,     10'd0, 22'd0,    11'd1024},
		'{ROW_REQ,  MODE_FREE,  22'd0,       STAT_DFREE,  10'd0, 22'd0,    11'd1024},
		'{ROW_REQ,  MODE_ALLOC, 22'd0,       STAT_OK,     10'd0, 22'd0,    11'd1023},
		'{ROW_REQ,  MODE_FREE,  22'd8184,    STAT_DFREE,  10'd0, 22'd0,    11'd1023},
		'{ROW_SIZE, MODE_ALLOC, 22'd8191,    STAT_OK,     10'd0, 22'd0,    11'd0},
		'{ROW_REQ,  MODE_ALLOC, 22'd0,       STAT_OK,     10'd1, 22'd8192, 11'd1022},
		'{ROW_REQ,  MODE_FREE,  22'd8192,    STAT_OK,     10'd1, 22'd8192, 11'd1023},
		'{ROW_REQ,  MODE_FREE,  22'd4096,    STAT_BADOFF, 10'd0, 22'd0,    11'd1023},
		'{ROW_SIZE, MODE_ALLOC, 22'd0,       STAT_OK,     10'd0, 22'd0,    11'd0},
		'{ROW_REQ,  MODE_ALLOC, 22'd0,       STAT_OK,     10'd1, 22'd8,    11'd1022},
		'{ROW_SIZE, MODE_ALLOC, 22'd13,      STAT_OK,     10'd0, 22'd0,    11'd0},
		'{ROW_REQ,  MODE_FREE,  22'd8,       STAT_BADOFF, 10'd0, 22'd0,    11'd1022},
		'{ROW_REQ,  MODE_FREE,  22'd16,      STAT_OK,     10'd1, 22'd16,   11'd1023},
		'{ROW_SIZE, MODE_ALLOC, 22'd4096,    STAT_OK,     10'd0, 22'd0,    11'd0},
		'{ROW_REQ,  MODE_FREE,  22'd4190208, STAT_DFREE,  10'd0, 22'd0,    11'd1023},
		'{ROW_REQ,  MODE_FREE,  22'h3FFFFF,  STAT_BADOFF, 10'd0, 22'd0,    11'd1023},
		'{ROW_REQ,  MODE_FREE,  22'd0,       STAT_OK,     10'd0, 22'd0,    11'd1024}
	};

	// Random phases: object size, request count, share of allocates, no idling
	typedef struct packed {
		logic [SIZE_W-1:0] size;
		int                count;
		int                alloc_pct;
		bit                quiet;
	} phase_t;

	localparam phase_t PHASES [PHASE_N] = '{
		'{13'd8191, 650, 95, 1'b0},
		'{13'd8,    500, 97, 1'b0},
		'{13'd24,   350, 25, 1'b0},
		'{13'd4095, 150, 50, 1'b1},
		'{13'd0,    150, 60, 1'b0}
	};

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 cfg_we    = 1'b0;
	logic [SIZE_W-1:0]    cfg_wdata = '0;
	logic                 s_tvalid  = 1'b0;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata   = '0;
	logic [0:0]           s_tuser   = '0;
	logic                 m_tvalid;
	logic                 m_tready  = 1'b0;
	logic [M_TDATA_W-1:0] m_tdata;
	logic [STATUS_W-1:0]  m_tuser;

	// Predicted allocator state
	bit [SLOTS-1:0]    slot_used;
	int unsigned       free_left = SLOTS;
	logic [SIZE_W-1:0] size_setting = 13'd8;

	slot_due_t results_due [$];

	bit quiet_phase;
	bit hold_req;
	int bad_results;
	int cycle_count;
	int requests_sent;
	int frees_done;
	int status_seen [4];

	bitmap_slot_allocator_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

	always #4 clk = ~clk;

	// Object size rounded up to eight bytes, zero taken as eight
	function automatic int unsigned object_bytes();
		int unsigned s;
		s = (int'(size_setting) + 7) & ~32'd7;
		return (s == 0) ? 8 : s;
	endfunction

	// First word not all ones, lowest clear bit: the lowest free slot overall
	function automatic int lowest_free_slot();
		for (int i = 0; i < SLOTS; i++)
			if (!slot_used[i])
				return i;
		return 0;
	endfunction

	// Result of one request; updates the predicted bitmap and free count
	function automatic slot_result_t serve_request(logic mode, logic [OFF_W-1:0] off);
		slot_result_t r;
		int unsigned sz;
		int unsigned slot;
		longint unsigned span;
		sz = object_bytes();
		r = '0;
		if (mode == MODE_ALLOC) begin
			if (free_left == 0) begin
				r.status = STAT_FULL;
			end else begin
				slot = lowest_free_slot();
				slot_used[slot] = 1'b1;
				free_left--;
				span = longint'(slot) * sz;
				r.status      = STAT_OK;
				r.slot_index  = slot[IDX_W-1:0];
				r.slot_offset = span[OFF_W-1:0];
			end
		end else if ((off % sz) != 0 || (off / sz) >= SLOTS) begin
			r.status = STAT_BADOFF;
		end else begin
			slot = off / sz;
			if (!slot_used[slot]) begin
				r.status = STAT_DFREE;
			end else begin
				slot_used[slot] = 1'b0;
				if (free_left < SLOTS)
					free_left++;
				r.status      = STAT_OK;
				r.slot_index  = slot[IDX_W-1:0];
				r.slot_offset = off;
			end
		end
		r.free_slots = free_left[FREE_W-1:0];
		return r;
	endfunction

	// Random slot in the wanted state whose offset fits the field
	function automatic bit pick_slot(bit want_used, output int unsigned slot);
		int unsigned start;
		int unsigned s;
		int unsigned sz;
		sz = object_bytes();
		start = $urandom_range(SLOTS - 1);
		slot = 0;
		for (int i = 0; i < SLOTS; i++) begin
			s = (start + i) % SLOTS;
			if (slot_used[s] == want_used && s * sz <= OFF_MAX) begin
				slot = s;
				return 1'b1;
			end
		end
		return 1'b0;
	endfunction

	// Allocates at alloc_pct percent; frees mostly of live slots, some noise, misaligned, out of range and double frees
	function automatic void make_request(int alloc_pct, output logic mode,
			output logic [OFF_W-1:0] off);
		int unsigned kind;
		int unsigned slot;
		int unsigned sz;
		sz = object_bytes();
		off = OFF_W'($urandom);
		mode = MODE_FREE;
		if ($urandom_range(99) < alloc_pct) begin
			mode = MODE_ALLOC;
		end else begin
			kind = $urandom_range(99);
			if (kind < 70) begin
				if (pick_slot(1'b1, slot))
					off = OFF_W'(slot * sz);
			end else if (kind < 75) begin
				off = OFF_W'((SLOTS + $urandom_range(3000)) * sz);
			end else if (kind < 80) begin
				off = OFF_W'($urandom);
			end else if (kind < 90) begin
				off = OFF_W'($urandom_range(SLOTS - 1) * sz + $urandom_range(sz - 1, 1));
			end else begin
				if (pick_slot(1'b0, slot))
					off = OFF_W'(slot * sz);
			end
		end
	endfunction

	function automatic int gap_len();
		int unsigned r;
		if (quiet_phase)
			return 0;
		r = $urandom_range(99);
		if (r < 65)
			return 0;
		if (r < 95)
			return $urandom_range(3, 1);
		return $urandom_range(30, 8);
	endfunction

	// Offer one request, wait for the transaction, queue its expected result
	task automatic send_request(logic mode, logic [OFF_W-1:0] off, bit typed,
			slot_result_t typed_res);
		slot_result_t want;
		int gap;
		s_tvalid <= 1'b1;
		s_tuser  <= mode;
		s_tdata  <= S_TDATA_W'(off);
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		want = serve_request(mode, off);
		if (typed)
			want = typed_res;
		results_due.push_back(slot_due_t'{mode: mode, res: want});
		requests_sent++;
		gap = gap_len();
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic hold_until_drained();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (results_due.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_object_size(logic [SIZE_W-1:0] size);
		hold_until_drained();
		cfg_we    <= 1'b1;
		cfg_wdata <= size;
		@(posedge clk);
		cfg_we    <= 1'b0;
		size_setting = size;
		@(posedge clk);
	endtask

	function automatic void report_bad(string what, slot_result_t want, slot_result_t got);
		bad_results++;
		if (bad_results <= REPORT_MAX)
			$display("%0t %s: expected st=%0d idx=%0d off=%0d free=%0d,",
				$realtime, what, want.status, want.slot_index, want.slot_offset,
				want.free_slots, " got st=%0d idx=%0d off=%0d free=%0d",
				got.status, got.slot_index, got.slot_offset, got.free_slots);
	endfunction

	// Result side: random stalls, one long hold-off on request
	initial begin : result_sink
		int idle;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				idle = HOLD_CYCLES;
			end else begin
				idle = gap_len();
			end
			if (idle == 0) begin
				m_tready <= 1'b1;
			end else begin
				m_tready <= 1'b0;
				repeat (idle) @(posedge clk);
				m_tready <= 1'b1;
			end
		end
	end

	// Compare each result transaction with the oldest expectation
	always @(posedge clk) begin : result_check
		slot_result_t got;
		slot_due_t due;
		if (arst_n && m_tvalid && m_tready) begin
			got.status      = m_tuser;
			got.slot_index  = m_tdata[IDX_W-1:0];
			got.slot_offset = m_tdata[IDX_W+OFF_W-1:IDX_W];
			got.free_slots  = m_tdata[IDX_W+OFF_W+FREE_W-1:IDX_W+OFF_W];
			if (results_due.size() == 0) begin
				report_bad("unexpected result", '0, got);
			end else begin
				due = results_due.pop_front();
				status_seen[due.res.status]++;
				if (due.mode == MODE_FREE && due.res.status == STAT_OK)
					frees_done++;
				if (got.status != due.res.status || got.slot_index != due.res.slot_index ||
						got.slot_offset != due.res.slot_offset ||
						got.free_slots != due.res.free_slots)
					report_bad("mismatch", due.res, got);
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == LIMIT_CYCLES) begin
			$display("testbench: timeout with %0d results outstanding", results_due.size());
			$display("testbench: done, errors");
			$finish;
		end
	end

	initial begin : stimulus
		dir_row_t row;
		phase_t ph;
		logic mode;
		logic [OFF_W-1:0] off;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// Directed rows: special cases with their results typed in
		for (int i = 0; i < DIR_N; i++) begin
			row = DIR_ROWS[i];
			if (row.kind == ROW_SIZE)
				write_object_size(row.arg[SIZE_W-1:0]);
			else
				send_request(row.mode, row.arg, 1'b1, slot_result_t'{row.status,
					row.slot_index, row.slot_offset, row.free_slots});
		end

		// Random phases checked against the predicted state
		for (int p = 0; p < PHASE_N; p++) begin
			ph = PHASES[p];
			write_object_size(ph.size);
			quiet_phase = ph.quiet;
			for (int n = 0; n < ph.count; n++) begin
				// long result-side stall, then a pause until everything is back
				if (p == 2 && n == 100)
					hold_req = 1'b1;
				if (p == 2 && n == 250)
					hold_until_drained();
				make_request(ph.alloc_pct, mode, off);
				send_request(mode, off, 1'b0, '0);
			end
		end

		hold_until_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("testbench: %0d requests over %0d object sizes in %0d cycles",
			requests_sent, PHASE_N + 5, cycle_count);
		$display("testbench: %0d granted, %0d freed, %0d full, %0d bad offset, %0d double free",
			status_seen[STAT_OK] - frees_done, frees_done, status_seen[STAT_FULL],
			status_seen[STAT_BADOFF], status_seen[STAT_DFREE]);
		if (bad_results == 0) begin
			$display("testbench: done, clean");
		end else begin
			$display("testbench: %0d bad results", bad_results);
			$display("testbench: done, errors");
		end
		$finish;
	end

endmodule
